FILE: hw/rtl/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared constants for the sum-checked frame receiver: frame markers, byte
// positions inside a frame and the result codes.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned OUTCOME_W = 2;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [OUTCOME_W-1:0] outcome_t;

	// frame markers
	localparam byte_t HDR_FIRST  = 8'h68;
	localparam byte_t HDR_SECOND = 8'hAA;
	localparam byte_t TAIL_BYTE  = 8'h16;
	localparam byte_t MIN_LENGTH = 8'd6;

	// byte positions inside a frame
	localparam byte_t POS_AFTER_FIRST = 8'd1;
	localparam byte_t POS_LEN         = 8'd2;
	localparam byte_t POS_STATE       = 8'd3;
	localparam byte_t POS_FLOW        = 8'd4;

	// result codes
	localparam outcome_t OUT_FRAME_OK  = 2'd0;
	localparam outcome_t OUT_CSUM_ERR  = 2'd1;
	localparam outcome_t OUT_FRAME_ERR = 2'd2;

endpackage

FILE: hw/rtl/sum_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// Parses 0x68 0xAA framed messages from a byte stream and checks their sum.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte
//   per item. The parser hunts for the header 0x68 0xAA, takes byte 2 as
//   the total frame length, bytes 3 and 4 as the state and flow codes, and
//   at the last byte checks the tail 0x16 and the 8-bit sum carried in the
//   byte before it.
//   Output channel (out_valid / out_stall) carries one item per finished or
//   aborted frame: outcome (ok, checksum error, framing/length error) plus
//   water_state and flow_step.
//   Throughput: one byte per cycle while no result is held by out_stall,
//   set by the single compare-and-add done per byte between the input
//   register and the result register. The last byte of a frame is taken into
//   the input register, then its result into the result register.
//   Reset: parser returns to hunting, all counts and codes cleared, both
//   pipeline registers empty.
//   Stall: while a result is held by out_stall the output register keeps
//   it; the input register still fills, then in_stall rises until the
//   result is taken.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scfr_pkg::byte_t     rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output scfr_pkg::outcome_t  outcome,
	output scfr_pkg::byte_t     water_state,
	output scfr_pkg::byte_t     flow_step
);
	import scfr_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HDR  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// input register
	logic  valid_s1;
	byte_t byte_s1;

	// parser state
	phase_t phase_q, phase_d;
	byte_t  pos_q, pos_d;
	byte_t  len_q, len_d;
	byte_t  sum_q, sum_d;
	byte_t  prev_q, prev_d;
	byte_t  state_q, state_d;
	byte_t  flow_q, flow_d;

	// result register
	logic     out_valid_q;
	outcome_t outcome_q;
	byte_t    water_q;
	byte_t    flow_out_q;

	logic     advance;
	logic     in_take;
	logic     emit;
	outcome_t code;
	byte_t    len_eff;
	logic [BYTE_W:0] pos_plus1;
	logic [BYTE_W:0] pos_plus2;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign len_eff   = (pos_q == POS_LEN) ? byte_s1 : len_q;
	assign pos_plus1 = {1'b0, pos_q} + (BYTE_W+1)'(1);
	assign pos_plus2 = {1'b0, pos_q} + (BYTE_W+1)'(2);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		sum_d   = sum_q;
		prev_d  = prev_q;
		state_d = state_q;
		flow_d  = flow_q;
		emit    = 1'b0;
		code    = OUT_FRAME_OK;
		unique case (phase_q)
			PH_HDR: begin
				if (byte_s1 == HDR_SECOND) begin
					phase_d = PH_BODY;
					pos_d   = POS_LEN;
					sum_d   = sum_q + byte_s1;
					prev_d  = byte_s1;
					state_d = '0;
					flow_d  = '0;
				end else if (byte_s1 == HDR_FIRST) begin
					// a repeated 0x68 starts a new header
					phase_d = PH_HDR;
					pos_d   = POS_AFTER_FIRST;
					sum_d   = byte_s1;
					prev_d  = byte_s1;
				end else begin
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
				end
			end
			PH_BODY: begin
				if (pos_q == POS_LEN) begin
					len_d = byte_s1;
				end
				if (pos_q == POS_STATE) begin
					state_d = byte_s1;
				end
				if (pos_q == POS_FLOW) begin
					flow_d = byte_s1;
				end
				priority if (pos_q == POS_LEN && byte_s1 < MIN_LENGTH) begin
					emit    = 1'b1;
					code    = OUT_FRAME_ERR;
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
				end else if (pos_plus1 == {1'b0, len_eff}) begin
					// last byte of the frame: tail then checksum
					emit    = 1'b1;
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
					if (byte_s1 != TAIL_BYTE) begin
						code = OUT_FRAME_ERR;
					end else if (prev_q == sum_q) begin
						code = OUT_FRAME_OK;
					end else begin
						code = OUT_CSUM_ERR;
					end
				end else begin
					// the checksum byte itself stays out of the sum
					if (pos_plus2 < {1'b0, len_eff}) begin
						sum_d = sum_q + byte_s1;
					end
					prev_d = byte_s1;
					pos_d  = pos_q + 8'd1;
				end
			end
			default: begin
				if (byte_s1 == HDR_FIRST) begin
					phase_d = PH_HDR;
					pos_d   = POS_AFTER_FIRST;
					sum_d   = byte_s1;
					prev_d  = byte_s1;
				end else begin
					phase_d = PH_HUNT;
					pos_d   = '0;
					sum_d   = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			pos_q       <= '0;
			len_q       <= '0;
			sum_q       <= '0;
			prev_q      <= '0;
			state_q     <= '0;
			flow_q      <= '0;
			out_valid_q <= 1'b0;
			outcome_q   <= OUT_FRAME_OK;
			water_q     <= '0;
			flow_out_q  <= '0;
		end else if (advance) begin
			if (valid_s1) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				len_q   <= len_d;
				sum_q   <= sum_d;
				prev_q  <= prev_d;
				state_q <= state_d;
				flow_q  <= flow_d;
			end
			out_valid_q <= valid_s1 && emit;
			if (valid_s1 && emit) begin
				outcome_q  <= code;
				water_q    <= state_d;
				flow_out_q <= flow_d;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign outcome     = outcome_q;
	assign water_state = water_q;
	assign flow_step   = flow_out_q;

endmodule

FILE: hw/rtl/scfr_checker.sv
// ----------------------------------------------------------------------------
// scfr_checker
// Port-level checks for the sum-checked frame receiver, bound to its top.
// ----------------------------------------------------------------------------
module scfr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input scfr_pkg::outcome_t  outcome,
	input scfr_pkg::byte_t     water_state,
	input scfr_pkg::byte_t     flow_step
);
	import scfr_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outcome)
			&& $stable(water_state) && $stable(flow_step))
		else $error("result changed while stalled");

	// only the three defined codes are ever reported
	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUT_FRAME_OK || outcome == OUT_CSUM_ERR
			|| outcome == OUT_FRAME_ERR))
		else $error("undefined outcome code");

	// the input side only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// a fresh result follows an accepted byte through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a byte two cycles earlier");

endmodule

bind sum_checked_frame_receiver scfr_checker u_scfr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.outcome     (outcome),
	.water_state (water_state),
	.flow_step   (flow_step)
);

FILE: bench/frame_outcome_check.sv
// ----------------------------------------------------------------------------
// frame_outcome_check
// Watches both channels of the sum-checked frame receiver. Every byte taken
// on the input channel runs through a parser model of its own; each finished
// or aborted frame queues an expected result. Each result taken on the output
// channel is compared field by field with the oldest one in the queue.
// ----------------------------------------------------------------------------
module frame_outcome_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  scfr_pkg::byte_t     rx_byte,
	input  logic                out_valid,
	input  logic                out_stall,
	input  scfr_pkg::outcome_t  outcome,
	input  scfr_pkg::byte_t     water_state,
	input  scfr_pkg::byte_t     flow_step,
	output int                  fail_count,
	output int                  pending
);

	import scfr_pkg::*;

	typedef enum logic [1:0] {
		HUNT_HEADER,
		WANT_SECOND,
		IN_FRAME
	} parse_phase_t;

	typedef struct packed {
		outcome_t code;
		byte_t    ws;
		byte_t    fs;
	} frame_result_t;

	parse_phase_t ph;
	byte_t pos;
	byte_t flen;
	byte_t run_sum;
	byte_t last_byte;
	byte_t st_code;
	byte_t fl_code;

	frame_result_t expected_outcomes [$];
	int n_fail;

	// returns 1 when this byte closes or aborts a frame
	function automatic bit parse_rx_byte(input byte_t rx, output frame_result_t res);
		bit done;
		outcome_t code;
		res = '0;
		done = 1'b0;
		code = OUT_FRAME_OK;
		if (ph == WANT_SECOND && rx == HDR_SECOND) begin
			ph = IN_FRAME;
			pos = POS_LEN;
			run_sum = run_sum + rx;
			last_byte = rx;
			st_code = '0;
			fl_code = '0;
			return 1'b0;
		end
		// a failed second header byte is itself a candidate first byte
		if (ph != IN_FRAME) begin
			if (rx == HDR_FIRST) begin
				ph = WANT_SECOND;
				pos = POS_AFTER_FIRST;
				run_sum = rx;
				last_byte = rx;
			end else begin
				ph = HUNT_HEADER;
				pos = '0;
				run_sum = '0;
			end
			return 1'b0;
		end
		if (pos == POS_LEN) begin
			flen = rx;
			if (rx < MIN_LENGTH) begin
				done = 1'b1;
				code = OUT_FRAME_ERR;
			end
		end else if (pos == POS_STATE) begin
			st_code = rx;
		end else if (pos == POS_FLOW) begin
			fl_code = rx;
		end
		if (!done && int'(pos) + 1 == int'(flen)) begin
			done = 1'b1;
			if (rx != TAIL_BYTE)
				code = OUT_FRAME_ERR;
			else if (last_byte == run_sum)
				code = OUT_FRAME_OK;
			else
				code = OUT_CSUM_ERR;
		end
		if (done) begin
			res.code = code;
			res.ws = st_code;
			res.fs = fl_code;
			ph = HUNT_HEADER;
			pos = '0;
			run_sum = '0;
			return 1'b1;
		end
		// checksum byte itself stays out of the sum
		if (int'(pos) + 2 < int'(flen))
			run_sum = run_sum + rx;
		last_byte = rx;
		pos = pos + 8'd1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		frame_result_t got;
		if (!arst_n) begin
			ph = HUNT_HEADER;
			pos = '0;
			flen = '0;
			run_sum = '0;
			last_byte = '0;
			st_code = '0;
			fl_code = '0;
			expected_outcomes.delete();
			n_fail = 0;
		end else begin
			// results trail their bytes, so check before taking this edge's byte
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result outcome %0d water_state %0d flow_step %0d",
						$time, outcome, water_state, flow_step);
					n_fail++;
				end else begin
					want = expected_outcomes.pop_front();
					if (outcome !== want.code) begin
						$display("%0t: outcome expected %0d actual %0d", $time, want.code, outcome);
						n_fail++;
					end
					if (water_state !== want.ws) begin
						$display("%0t: water_state expected %0d actual %0d",
							$time, want.ws, water_state);
						n_fail++;
					end
					if (flow_step !== want.fs) begin
						$display("%0t: flow_step expected %0d actual %0d",
							$time, want.fs, flow_step);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_rx_byte(rx_byte, got))
					expected_outcomes.push_back(got);
			end
		end
		fail_count <= n_fail;
		pending <= expected_outcomes.size();
	end

endmodule

FILE: bench/sum_checked_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_tb
// Feeds the frame receiver a byte stream: a short directed run through the
// header, length, tail and checksum corner cases, then random frames (good,
// bad sum, bad tail) mixed with short lengths, broken headers and line noise.
// Both sides idle and stall at random; an outcome checker scores every result.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver_tb;

	import scfr_pkg::*;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_SUM,
		FRAME_BAD_TAIL
	} frame_kind_t;

	localparam int RANDOM_ITEMS = 1950;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	byte_t    rx_byte;
	logic     out_valid;
	logic     out_stall;
	outcome_t outcome;
	byte_t    water_state;
	byte_t    flow_step;
	int       fail_count;
	int       pending;

	bit tx_quiet;
	bit rx_quiet;
	int items_sent;

	sum_checked_frame_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.outcome     (outcome),
		.water_state (water_state),
		.flow_step   (flow_step)
	);

	frame_outcome_check outcome_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.outcome     (outcome),
		.water_state (water_state),
		.flow_step   (flow_step),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int pick_wait(input bit quiet);
		if (quiet)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 18);
		return $urandom_range(0, 2);
	endfunction

	task automatic send_byte(input byte_t b);
		int gap;
		gap = pick_wait(tx_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input int len, input byte_t st, input byte_t fl,
			input frame_kind_t kind);
		byte_t fb [0:255];
		byte_t cs;
		cs = '0;
		fb[0] = HDR_FIRST;
		fb[1] = HDR_SECOND;
		fb[2] = byte_t'(len);
		for (int i = 3; i < len; i++)
			fb[i] = byte_t'($urandom_range(0, 255));
		fb[3] = st;
		fb[4] = fl;
		for (int i = 0; i <= len - 3; i++)
			cs = cs + fb[i];
		if (kind == FRAME_BAD_SUM)
			cs = cs ^ byte_t'($urandom_range(1, 255));
		// for the shortest frame the checksum lands on the flow byte
		fb[len - 2] = cs;
		fb[len - 1] = (kind == FRAME_BAD_TAIL) ? (TAIL_BYTE ^ byte_t'($urandom_range(1, 255)))
			: TAIL_BYTE;
		for (int i = 0; i < len; i++)
			send_byte(fb[i]);
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		int gap;
		out_stall <= 1'b0;
		forever begin
			gap = pick_wait(rx_quiet);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int pick;
		int len;
		bit pressure_done;
		byte_t nb;
		frame_kind_t kind;
		in_valid <= 1'b0;
		rx_byte <= '0;
		arst_n <= 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		items_sent = 0;
		pressure_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// header restart on a repeated first byte, then a short length
		send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(8'd5);
		// zero length
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(8'd0);
		send_frame(7, 8'hFF, 8'h00, FRAME_GOOD);
		send_frame(6, 8'h00, 8'hFF, FRAME_BAD_SUM);
		send_frame(6, 8'h12, 8'h34, FRAME_BAD_TAIL);

		drain_results();
		items_sent = 0;

		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 29) == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				len = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 255)
					: $urandom_range(6, 16);
				case ($urandom_range(0, 9))
					0, 1:    kind = FRAME_BAD_SUM;
					2, 3:    kind = FRAME_BAD_TAIL;
					default: kind = FRAME_GOOD;
				endcase
				send_frame(len, byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(0, 255)), kind);
			end else if (pick < 82) begin
				send_byte(HDR_FIRST);
				send_byte(HDR_SECOND);
				send_byte(byte_t'($urandom_range(0, 5)));
			end else if (pick < 90) begin
				nb = byte_t'($urandom_range(0, 255));
				if (nb == HDR_SECOND)
					nb = ~nb;
				send_byte(HDR_FIRST);
				send_byte(nb);
			end else begin
				send_byte(byte_t'($urandom_range(0, 255)));
			end
			if (!pressure_done && items_sent >= RANDOM_ITEMS / 2) begin
				// let the pipeline run dry, then the longest frame
				drain_results();
				send_frame(255, byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(0, 255)), FRAME_GOOD);
				pressure_done = 1'b1;
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sum_checked_frame_receiver.f
hw/rtl/scfr_pkg.sv
hw/rtl/sum_checked_frame_receiver.sv
hw/rtl/scfr_checker.sv
bench/frame_outcome_check.sv
bench/sum_checked_frame_receiver_tb.sv
